>>> hdl/weighted_sketch_counter_update_defines.svh
// ----------------------------------------------------------------------------
// weighted sketch counter update - assertion macros
// property forms used by the assertions of the sketch block
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_SKETCH_COUNTER_UPDATE_DEFINES_SVH
`define WEIGHTED_SKETCH_COUNTER_UPDATE_DEFINES_SVH

// same-cycle implication
`define WSCU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WSCU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/wscu_pkg.sv
// ----------------------------------------------------------------------------
// wscu_pkg
// types and constants shared by the sketch counter block
// ----------------------------------------------------------------------------
`default_nettype none

package wscu_pkg;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] flow_key;
		logic [15:0] payload_size;
		logic [7:0]  card_step;
		logic [1:0]  row;
		logic [9:0]  bucket;
		logic [13:0] weight_index;
		logic [17:0] weight_value;
	} in_item_t;

	typedef struct packed {
		logic [47:0] volume_out;
		logic [31:0] cardinality_out;
		logic [47:0] total_payload;
	} out_item_t;

	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_PAYLOAD = 2'd1;
	localparam logic [1:0] CMD_ID      = 2'd2;
	localparam logic [1:0] CMD_READ    = 2'd3;

	localparam int WEIGHT_ENTRIES = 10000;
	localparam int WIDX_W         = 14;
	localparam int MOD_W          = 17;

	// floor(2^32 / WEIGHT_ENTRIES) for the reciprocal reduction
	localparam logic [31:0] RECIP_WGT = 32'(64'h1_0000_0000 / 64'(WEIGHT_ENTRIES));

	localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2  = 32'h1b873593;
	localparam logic [31:0] MM_M5  = 32'd5;
	localparam logic [31:0] MM_N   = 32'he6546b64;
	localparam logic [31:0] MM_LEN = 32'd4;
	localparam logic [31:0] MM_F1  = 32'h85ebca6b;
	localparam logic [31:0] MM_F2  = 32'hc2b2ae35;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_MSTART,
		ST_MOD,
		ST_WRD,
		ST_WMUL,
		ST_WSAVE,
		ST_CRD,
		ST_CWR,
		ST_RESP
	} state_t;

	typedef enum logic [2:0] {
		ALU_K1,
		ALU_K2,
		ALU_H,
		ALU_F1,
		ALU_F2,
		ALU_WMUL
	} alu_op_t;

	typedef struct packed {
		logic    en;
		alu_op_t op;
	} alu_ctl_t;

endpackage

`default_nettype wire

>>> hdl/weighted_sketch_counter_update.sv
// ----------------------------------------------------------------------------
// weighted_sketch_counter_update
// weighted count-min sketch with murmur3 bucket and weight selection
// ----------------------------------------------------------------------------
// usage:
//   drive command and raise start; the item is taken on an edge where busy is
//   low. done pulses for one cycle with result valid; the receiver must take
//   it then, it cannot hold the block off.
//   each row runs murmur3 through one shared multiplier and then a
//   reciprocal-multiply modulo unit; a payload insert needs two hashes per
//   row plus a weight read and product, an id insert one hash.
//   one item at a time: busy stays high until the cycle after done, so a new
//   item is taken in the cycle after a result at the earliest.
//   after reset busy stays high while the counter memories are swept to
//   zero; each holds 2^(RW+clog2(BUCKETS)) entries, RW being clog2(ROWS) but
//   at least 1 (4096 at the default size). the weight table is not cleared
//   and must be loaded before payload inserts use it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "weighted_sketch_counter_update_defines.svh"

module weighted_sketch_counter_update #(
	parameter int ROWS    = 4,
	parameter int BUCKETS = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wscu_pkg::in_item_t        command,
	output      logic                 busy,
	output      logic                 done,
	output      wscu_pkg::out_item_t  result
);

	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BW    = $clog2(BUCKETS);
	localparam int AW    = RW + BW;
	localparam int DEPTH = 1 << AW;
	localparam logic [31:0] RECIP_BKT = 32'(64'h1_0000_0000 / 64'(BUCKETS));

	wscu_pkg::state_t   state_q;
	wscu_pkg::state_t   state_nxt;
	wscu_pkg::alu_ctl_t alu_ctl;

	logic [2:0]    step_q;
	logic [RW-1:0] row_q;
	logic          pass_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] clr_q;
	logic          is_read_q;
	logic          in_range_q;
	logic          is_pay_q;
	wscu_pkg::in_item_t item_q;
	logic [47:0]   total_q;
	logic [wscu_pkg::WIDX_W-1:0] widx_q;
	logic [33:0]   inc_q;
	logic          last_row;

	logic [17:0] wmem [0:wscu_pkg::WEIGHT_ENTRIES-1];
	logic [17:0] w_rd_q;
	logic [47:0] vmem [0:DEPTH-1];
	logic [31:0] cmem [0:DEPTH-1];
	logic [47:0] vol_rd_q;
	logic [31:0] card_rd_q;

	logic        mod_start;
	logic        mod_ready;
	logic [wscu_pkg::MOD_W-1:0] mod_rem;
	logic [wscu_pkg::MOD_W-1:0] modulus;
	logic [31:0] recip;
	logic [31:0] hash_fin;
	logic [33:0] alu_prod;
	logic [31:0] seed;
	logic        accept;

	logic [48:0] vol_sum;
	logic [32:0] card_sum;
	logic [48:0] tot_sum;
	logic [47:0] vol_new;
	logic [31:0] card_new;
	logic [4:0]  rd_row;
	logic [16:0] rd_bkt;
	logic [wscu_pkg::MOD_W-1:0] rem_wide;

	assign accept   = start && !busy;
	assign last_row = (row_q == RW'(ROWS - 1));
	assign seed     = pass_q ? 32'(row_q) : 32'(row_q) + 32'(ROWS);
	assign modulus  = pass_q ? wscu_pkg::MOD_W'(BUCKETS)
	                         : wscu_pkg::MOD_W'(wscu_pkg::WEIGHT_ENTRIES);
	assign recip    = pass_q ? RECIP_BKT : wscu_pkg::RECIP_WGT;
	assign rem_wide = mod_rem;

	wscu_alu u_alu (
		.clk    (clk),
		.ctl    (alu_ctl),
		.key    (item_q.flow_key),
		.seed   (seed),
		.pay    (item_q.payload_size),
		.weight (w_rd_q),
		.fin    (hash_fin),
		.prod   (alu_prod)
	);

	wscu_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.value   (hash_fin),
		.modulus (modulus),
		.recip   (recip),
		.ready   (mod_ready),
		.rem     (mod_rem)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			wscu_pkg::ST_CLEAR: begin
				if (clr_q == {AW{1'b1}}) state_nxt = wscu_pkg::ST_IDLE;
			end
			wscu_pkg::ST_IDLE: begin
				if (start) begin
					if (command.cmd == wscu_pkg::CMD_LOAD) begin
						state_nxt = wscu_pkg::ST_RESP;
					end else if (command.cmd == wscu_pkg::CMD_READ) begin
						state_nxt = wscu_pkg::ST_CRD;
					end else begin
						state_nxt = wscu_pkg::ST_HASH;
					end
				end
			end
			wscu_pkg::ST_HASH: begin
				if (step_q == 3'd4) state_nxt = wscu_pkg::ST_MSTART;
			end
			wscu_pkg::ST_MSTART: state_nxt = wscu_pkg::ST_MOD;
			wscu_pkg::ST_MOD: begin
				if (mod_ready) state_nxt = pass_q ? wscu_pkg::ST_CRD : wscu_pkg::ST_WRD;
			end
			wscu_pkg::ST_WRD:   state_nxt = wscu_pkg::ST_WMUL;
			wscu_pkg::ST_WMUL:  state_nxt = wscu_pkg::ST_WSAVE;
			wscu_pkg::ST_WSAVE: state_nxt = wscu_pkg::ST_HASH;
			wscu_pkg::ST_CRD: begin
				state_nxt = is_read_q ? wscu_pkg::ST_RESP : wscu_pkg::ST_CWR;
			end
			wscu_pkg::ST_CWR: begin
				state_nxt = last_row ? wscu_pkg::ST_RESP : wscu_pkg::ST_HASH;
			end
			wscu_pkg::ST_RESP: state_nxt = wscu_pkg::ST_IDLE;
			default: state_nxt = wscu_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		alu_ctl.en = 1'b0;
		alu_ctl.op = wscu_pkg::ALU_K1;
		mod_start  = 1'b0;
		busy       = 1'b1;
		done       = 1'b0;
		case (state_q)
			wscu_pkg::ST_IDLE: busy = 1'b0;
			wscu_pkg::ST_HASH: begin
				alu_ctl.en = 1'b1;
				case (step_q)
					3'd0:    alu_ctl.op = wscu_pkg::ALU_K1;
					3'd1:    alu_ctl.op = wscu_pkg::ALU_K2;
					3'd2:    alu_ctl.op = wscu_pkg::ALU_H;
					3'd3:    alu_ctl.op = wscu_pkg::ALU_F1;
					default: alu_ctl.op = wscu_pkg::ALU_F2;
				endcase
			end
			wscu_pkg::ST_MSTART: mod_start = 1'b1;
			wscu_pkg::ST_WMUL: begin
				alu_ctl.en = 1'b1;
				alu_ctl.op = wscu_pkg::ALU_WMUL;
			end
			wscu_pkg::ST_RESP: done = 1'b1;
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wscu_pkg::ST_CLEAR;
			clr_q   <= '0;
			step_q  <= 3'd0;
			row_q   <= '0;
			pass_q  <= 1'b0;
			total_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == wscu_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			step_q <= (state_q == wscu_pkg::ST_HASH) ? step_q + 3'd1 : 3'd0;
			if (accept) begin
				row_q  <= '0;
				// id inserts skip the weight hash
				pass_q <= (command.cmd == wscu_pkg::CMD_ID);
				if (command.cmd == wscu_pkg::CMD_PAYLOAD) begin
					total_q <= tot_sum[48] ? {48{1'b1}} : tot_sum[47:0];
				end
			end else if (state_q == wscu_pkg::ST_MOD && mod_ready && !pass_q) begin
				pass_q <= 1'b1;
			end else if (state_q == wscu_pkg::ST_CWR && !last_row) begin
				row_q  <= row_q + 1'b1;
				pass_q <= !is_pay_q;
			end
		end
	end

	assign tot_sum = {1'b0, total_q} + 49'(command.payload_size);
	assign rd_row  = 5'(command.row);
	assign rd_bkt  = 17'(command.bucket);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q     <= command;
			is_read_q  <= (command.cmd == wscu_pkg::CMD_READ);
			is_pay_q   <= (command.cmd == wscu_pkg::CMD_PAYLOAD);
			in_range_q <= (32'(command.row) < 32'(ROWS)) &&
			              (32'(command.bucket) < 32'(BUCKETS));
			addr_q     <= {rd_row[RW-1:0], rd_bkt[BW-1:0]};
		end else if (state_q == wscu_pkg::ST_MOD && mod_ready) begin
			if (pass_q) begin
				addr_q <= {row_q, rem_wide[BW-1:0]};
			end else begin
				widx_q <= rem_wide[wscu_pkg::WIDX_W-1:0];
			end
		end
		if (state_q == wscu_pkg::ST_WSAVE) inc_q <= alu_prod;
	end

	// weight table
	always_ff @(posedge clk) begin
		if (accept && command.cmd == wscu_pkg::CMD_LOAD &&
		    32'(command.weight_index) < 32'(wscu_pkg::WEIGHT_ENTRIES)) begin
			wmem[command.weight_index] <= command.weight_value;
		end
		if (state_q == wscu_pkg::ST_WRD) w_rd_q <= wmem[widx_q];
	end

	assign vol_sum  = {1'b0, vol_rd_q} + 49'(inc_q);
	assign card_sum = {1'b0, card_rd_q} + 33'(item_q.card_step);
	assign vol_new  = vol_sum[48] ? {48{1'b1}} : vol_sum[47:0];
	assign card_new = card_sum[32] ? {32{1'b1}} : card_sum[31:0];

	// counter memories
	always_ff @(posedge clk) begin
		if (state_q == wscu_pkg::ST_CLEAR) begin
			vmem[clr_q] <= '0;
			cmem[clr_q] <= '0;
		end else if (state_q == wscu_pkg::ST_CWR) begin
			if (is_pay_q) vmem[addr_q] <= vol_new;
			cmem[addr_q] <= card_new;
		end
		if (state_q == wscu_pkg::ST_CRD) begin
			vol_rd_q  <= vmem[addr_q];
			card_rd_q <= cmem[addr_q];
		end
	end

	assign result.volume_out      = (is_read_q && in_range_q) ? vol_rd_q : '0;
	assign result.cardinality_out = (is_read_q && in_range_q) ? card_rd_q : '0;
	assign result.total_payload   = total_q;

	`WSCU_ASSERT_NEXT(a_done_then_idle, done, !busy, "done not followed by idle")
	`WSCU_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not raise busy")
	`WSCU_ASSERT_NOW(a_row_range, state_q == wscu_pkg::ST_CWR, 32'(row_q) < 32'(ROWS),
		"counter write on a row beyond the sketch")
	`WSCU_ASSERT_NOW(a_mod_idle_start, mod_start, mod_ready, "modulo restarted while running")

endmodule

`default_nettype wire

>>> hdl/wscu_alu.sv
// ----------------------------------------------------------------------------
// wscu_alu
// shared 32x32 multiplier with the hash pre/post steps around it
// ----------------------------------------------------------------------------
`default_nettype none

module wscu_alu (
	input  wire                logic        clk,
	input  wscu_pkg::alu_ctl_t              ctl,
	input  wire                logic [31:0] key,
	input  wire                logic [31:0] seed,
	input  wire                logic [15:0] pay,
	input  wire                logic [17:0] weight,
	output                     logic [31:0] fin,
	output                     logic [33:0] prod
);

	logic [63:0] prod_q;
	logic [31:0] acc;
	logic [31:0] mix;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] mul;
	logic [63:0] nxt;

	assign acc = prod_q[31:0];
	assign mix = seed ^ acc;
	assign mul = {32'b0, op_a} * {32'b0, op_b};

	always_comb begin
		op_a = key;
		op_b = wscu_pkg::MM_C1;
		nxt  = {32'b0, mul[31:0]};
		case (ctl.op)
			wscu_pkg::ALU_K1: begin
				op_a = key;
				op_b = wscu_pkg::MM_C1;
			end
			wscu_pkg::ALU_K2: begin
				op_a = {acc[16:0], acc[31:17]};
				op_b = wscu_pkg::MM_C2;
			end
			wscu_pkg::ALU_H: begin
				op_a = {mix[18:0], mix[31:19]};
				op_b = wscu_pkg::MM_M5;
				nxt  = {32'b0, (mul[31:0] + wscu_pkg::MM_N) ^ wscu_pkg::MM_LEN};
			end
			wscu_pkg::ALU_F1: begin
				op_a = acc ^ (acc >> 16);
				op_b = wscu_pkg::MM_F1;
			end
			wscu_pkg::ALU_F2: begin
				op_a = acc ^ (acc >> 13);
				op_b = wscu_pkg::MM_F2;
			end
			wscu_pkg::ALU_WMUL: begin
				op_a = {16'b0, pay};
				op_b = {14'b0, weight};
				nxt  = mul;
			end
			default: begin
				op_a = key;
				op_b = wscu_pkg::MM_C1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_q <= nxt;
		end
	end

	assign fin  = acc ^ (acc >> 16);
	assign prod = prod_q[33:0];

endmodule

`default_nettype wire

>>> hdl/wscu_mod.sv
// ----------------------------------------------------------------------------
// wscu_mod
// floor modulo of a signed 32-bit hash by reciprocal multiplication
// ----------------------------------------------------------------------------
`default_nettype none

module wscu_mod (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [31:0]                value,
	input  wire logic [wscu_pkg::MOD_W-1:0] modulus,
	input  wire logic [31:0]                recip,
	output      logic                       ready,
	output      logic [wscu_pkg::MOD_W-1:0] rem
);

	logic [1:0]                 cnt_q;
	logic [31:0]                x_q;
	logic                       neg_q;
	logic [63:0]                prod_q;
	logic [31:0]                op_a;
	logic [31:0]                op_b;
	logic [63:0]                mul;
	logic [31:0]                r_est;
	logic [wscu_pkg::MOD_W:0]   r_fix;
	logic [wscu_pkg::MOD_W:0]   r_sub;
	logic [wscu_pkg::MOD_W-1:0] r_red;

	// first pass: quotient estimate x * recip >> 32, second pass: quotient * modulus
	assign op_a = (cnt_q == 2'd2) ? x_q : prod_q[63:32];
	assign op_b = (cnt_q == 2'd2) ? recip : 32'(modulus);
	assign mul  = {32'b0, op_a} * {32'b0, op_b};

	// estimate falls short by at most one modulus
	assign r_est = x_q - prod_q[31:0];
	assign r_fix = r_est[wscu_pkg::MOD_W:0];
	assign r_sub = r_fix - {1'b0, modulus};
	assign r_red = (r_fix >= {1'b0, modulus}) ? r_sub[wscu_pkg::MOD_W-1:0]
	                                          : r_fix[wscu_pkg::MOD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (start) begin
			cnt_q <= 2'd2;
		end else if (cnt_q != 2'd0) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// negative hash: reduce the magnitude, fix up at the end
			neg_q <= value[31];
			x_q   <= value[31] ? (32'd0 - value) : value;
		end else if (cnt_q != 2'd0) begin
			prod_q <= mul;
		end
	end

	assign ready = (cnt_q == 2'd0);
	assign rem   = (neg_q && (r_red != '0)) ? modulus - r_red : r_red;

endmodule

`default_nettype wire

>>> tb/sv/weighted_sketch_counter_update_tb.sv
// ----------------------------------------------------------------------------
// weighted_sketch_counter_update_tb
// drives load, insert and read commands into the sketch block, predicts each
// result with a local murmur3 sketch model and checks every result field
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_sketch_counter_update_tb;

	localparam int NROWS    = 4;
	localparam int NBUCKETS = 1024;
	localparam int NCELLS   = NROWS * NBUCKETS;
	localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
	localparam int WATCHDOG = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	wscu_pkg::in_item_t command = '0;
	logic busy;
	logic done;
	wscu_pkg::out_item_t result;

	weighted_sketch_counter_update #(.ROWS(NROWS), .BUCKETS(NBUCKETS)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.busy(busy), .done(done), .result(result)
	);

	always #1 clk = ~clk;

	// sketch model state
	logic [47:0] vol_mem [NCELLS];
	logic [31:0] card_mem [NCELLS];
	logic [17:0] weights [wscu_pkg::WEIGHT_ENTRIES];
	// set when a load for the entry has been queued
	bit          weight_loaded [wscu_pkg::WEIGHT_ENTRIES];
	logic [47:0] pay_sum;

	wscu_pkg::in_item_t  pending_items [$];
	wscu_pkg::out_item_t expected_results [$];
	int  errors = 0;
	int  send_idle_pct = 31;
	int  wd_count = 0;
	bit  stim_done = 0;

	function automatic logic [31:0] rotl(logic [31:0] x, int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] murmur3(logic [31:0] key, logic [31:0] seed);
		logic [31:0] h;
		logic [31:0] k;
		k = key * 32'hcc9e2d51;
		k = rotl(k, 15);
		k = k * 32'h1b873593;
		h = seed ^ k;
		h = rotl(h, 13);
		h = h * 32'd5 + 32'he6546b64;
		h = h ^ 32'd4;
		h = h ^ (h >> 16);
		h = h * 32'h85ebca6b;
		h = h ^ (h >> 13);
		h = h * 32'hc2b2ae35;
		h = h ^ (h >> 16);
		return h;
	endfunction

	// hash read as signed, floor modulo m
	function automatic int floor_mod(logic [31:0] h, int m);
		longint v;
		longint r;
		v = longint'($signed(h));
		r = v % m;
		if (r < 0) r += m;
		return int'(r);
	endfunction

	function automatic logic [47:0] add_sat48(logic [47:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {17'd0, a} + {1'b0, b};
		return (s > {17'd0, SAT48}) ? SAT48 : s[47:0];
	endfunction

	function automatic wscu_pkg::out_item_t sketch_apply(wscu_pkg::in_item_t it);
		wscu_pkg::out_item_t o;
		int b;
		int wi;
		int slot;
		logic [32:0] cs;
		o = '0;
		case (it.cmd)
			wscu_pkg::CMD_LOAD: begin
				if (it.weight_index < wscu_pkg::WEIGHT_ENTRIES)
					weights[it.weight_index] = it.weight_value;
			end
			wscu_pkg::CMD_PAYLOAD, wscu_pkg::CMD_ID: begin
				if (it.cmd == wscu_pkg::CMD_PAYLOAD)
					pay_sum = add_sat48(pay_sum, {48'd0, it.payload_size});
				for (int r = 0; r < NROWS; r++) begin
					b = floor_mod(murmur3(it.flow_key, 32'(r)), NBUCKETS);
					slot = r * NBUCKETS + b;
					if (it.cmd == wscu_pkg::CMD_PAYLOAD) begin
						wi = floor_mod(murmur3(it.flow_key, 32'(r + NROWS)),
							wscu_pkg::WEIGHT_ENTRIES);
						vol_mem[slot] = add_sat48(vol_mem[slot],
							64'(it.payload_size) * 64'(weights[wi]));
					end
					cs = {1'b0, card_mem[slot]} + 33'(it.card_step);
					card_mem[slot] = cs[32] ? SAT32 : cs[31:0];
				end
			end
			default: begin
				if (it.row < NROWS && it.bucket < NBUCKETS) begin
					o.volume_out = vol_mem[it.row * NBUCKETS + it.bucket];
					o.cardinality_out = card_mem[it.row * NBUCKETS + it.bucket];
				end
			end
		endcase
		o.total_payload = pay_sum;
		return o;
	endfunction

	function automatic bit key_weights_ready(logic [31:0] key);
		for (int r = 0; r < NROWS; r++)
			if (!weight_loaded[floor_mod(murmur3(key, 32'(r + NROWS)),
					wscu_pkg::WEIGHT_ENTRIES)])
				return 0;
		return 1;
	endfunction

	function automatic wscu_pkg::in_item_t rand_fields();
		wscu_pkg::in_item_t it;
		it.cmd = 2'($urandom_range(0, 3));
		it.flow_key = $urandom;
		it.payload_size = 16'($urandom);
		it.card_step = 8'($urandom);
		it.row = 2'($urandom);
		it.bucket = 10'($urandom);
		it.weight_index = 14'($urandom);
		it.weight_value = 18'($urandom);
		return it;
	endfunction

	// mostly extreme weights
	function automatic logic [17:0] weight_pick(int i);
		case (i % 4)
			0: return 18'h3FFFF;
			1: return 18'h10000;
			2: return '0;
			default: return 18'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!(start && !busy) && start) begin
				// still waiting for acceptance
			end else if (pending_items.size() > 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				command <= pending_items.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
				command <= rand_fields();
			end
		end
	end

	// prediction at acceptance
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			expected_results.push_back(sketch_apply(command));
	end

	// monitor
	always @(posedge clk) begin
		wscu_pkg::out_item_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				want = expected_results.pop_front();
				if (result.volume_out !== want.volume_out)
					report_mismatch("volume_out", result.volume_out, want.volume_out);
				if (result.cardinality_out !== want.cardinality_out)
					report_mismatch("cardinality_out", result.cardinality_out,
						want.cardinality_out);
				if (result.total_payload !== want.total_payload)
					report_mismatch("total_payload", result.total_payload,
						want.total_payload);
			end
		end
	end

	// watchdog; the post-reset sweep counts as stalled cycles
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			wd_count <= 0;
		else
			wd_count <= wd_count + 1;
		if (wd_count >= WATCHDOG) begin
			$display("weighted_sketch_counter_update_tb: FAIL");
			$finish;
		end
	end

	task automatic push_item(wscu_pkg::in_item_t it);
		if (it.cmd == wscu_pkg::CMD_LOAD && it.weight_index < wscu_pkg::WEIGHT_ENTRIES)
			weight_loaded[it.weight_index] = 1;
		pending_items.push_back(it);
	endtask

	// queue loads for the weight entries a payload insert of this key reads that have none queued yet
	task automatic ensure_weights(logic [31:0] key);
		int wi;
		wscu_pkg::in_item_t it;
		for (int r = 0; r < NROWS; r++) begin
			wi = floor_mod(murmur3(key, 32'(r + NROWS)), wscu_pkg::WEIGHT_ENTRIES);
			if (!weight_loaded[wi]) begin
				it = rand_fields();
				it.cmd = wscu_pkg::CMD_LOAD;
				it.weight_index = 14'(wi);
				it.weight_value = weight_pick(wi);
				push_item(it);
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || expected_results.size() > 0 || start)
			@(posedge clk);
	endtask

	initial begin
		wscu_pkg::in_item_t it;
		logic [31:0] hot_keys [4];
		int n;
		for (int i = 0; i < NCELLS; i++) begin
			vol_mem[i] = '0;
			card_mem[i] = '0;
		end
		for (int i = 0; i < wscu_pkg::WEIGHT_ENTRIES; i++) begin
			weights[i] = '0;
			weight_loaded[i] = 0;
		end
		pay_sum = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: out-of-range loads, extreme inserts, reads of the first, last and key-0 cells
		it = rand_fields(); it.cmd = wscu_pkg::CMD_LOAD; it.weight_index = 14'h3FFF;
		push_item(it);
		it = rand_fields(); it.cmd = wscu_pkg::CMD_LOAD;
		it.weight_index = 14'(wscu_pkg::WEIGHT_ENTRIES);
		push_item(it);
		ensure_weights(32'h0);
		ensure_weights(32'hFFFF_FFFF);
		it = rand_fields(); it.cmd = wscu_pkg::CMD_PAYLOAD; it.flow_key = '0;
		it.payload_size = 16'hFFFF; it.card_step = 8'hFF; push_item(it);
		it = rand_fields(); it.cmd = wscu_pkg::CMD_PAYLOAD; it.flow_key = '1;
		it.payload_size = '0; it.card_step = '0; push_item(it);
		it = rand_fields(); it.cmd = wscu_pkg::CMD_ID; it.flow_key = 32'h8000_0000;
		it.card_step = 8'hFF; push_item(it);
		it = rand_fields(); it.cmd = wscu_pkg::CMD_READ; it.row = 0; it.bucket = 0;
		push_item(it);
		it = rand_fields(); it.cmd = wscu_pkg::CMD_READ; it.row = 3; it.bucket = 10'h3FF;
		push_item(it);
		for (int r = 0; r < NROWS; r++) begin
			it = rand_fields(); it.cmd = wscu_pkg::CMD_READ; it.row = 2'(r);
			it.bucket = 10'(floor_mod(murmur3(32'h0, 32'(r)), NBUCKETS)); push_item(it);
		end

		// random: hot keys get hammered so counters grow; phases change idling
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 31 : (p == 1) ? 83 : 0;
			for (int k = 0; k < 4; k++) begin
				hot_keys[k] = $urandom;
				ensure_weights(hot_keys[k]);
			end
			for (n = 0; n < 110; n++) begin
				it = rand_fields();
				if ($urandom_range(0, 3) != 0) it.flow_key = hot_keys[$urandom_range(0, 3)];
				if (it.cmd == wscu_pkg::CMD_READ && $urandom_range(0, 2) != 0) begin
					it.row = 2'($urandom_range(0, NROWS - 1));
					it.bucket = 10'(floor_mod(murmur3(hot_keys[$urandom_range(0, 3)],
						32'(it.row)), NBUCKETS));
				end
				if ($urandom_range(0, 3) == 0) it.card_step = 8'hFF;
				if (it.cmd == wscu_pkg::CMD_PAYLOAD && !key_weights_ready(it.flow_key))
					ensure_weights(it.flow_key);
				push_item(it);
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("weighted_sketch_counter_update_tb: PASS");
		else
			$display("weighted_sketch_counter_update_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
+incdir+hdl
hdl/wscu_pkg.sv
hdl/wscu_alu.sv
hdl/wscu_mod.sv
hdl/weighted_sketch_counter_update.sv
tb/sv/weighted_sketch_counter_update_tb.sv
